/* rtl/wcp_pkg.sv */
// Shared types, constants and register map for the weighted centroid peak refine block.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package wcp_pkg;

    // Fixed field widths
    localparam int CFG_DIM_W  = 11;
    localparam int CFG_BOX_W  = 4;
    localparam int PEAK_W     = 10;
    localparam int PIX_W      = 16;
    localparam int CENT_W     = 19;
    localparam int TW_W       = 24;
    localparam int FRAC_W     = 8;
    localparam int QUO_W      = CENT_W + 2;  // two bits wider than the centroid field

    // Stream widths
    localparam int S_TDATA_W  = 40;  // 10 + 10 + 16, padded to bytes
    localparam int M_TDATA_W  = 64;  // 19 + 19 + 24, padded to bytes
    localparam int M_TUSER_W  = 2;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_DIM = 1024;
    localparam int DEF_MAX_BOX = 15;

    // Centroid limits as magnitudes
    localparam int CENT_POS_MAX = 262143;
    localparam int CENT_NEG_MAG = 262144;

    // Input kinds carried on tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // APB register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd3;

    // Register reset values
    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_COLS = 11'd1024;
    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_ROWS = 11'd1024;
    localparam logic [CFG_BOX_W-1:0] RST_BOX_WIDTH  = 4'd5;
    localparam logic [CFG_BOX_W-1:0] RST_BOX_HEIGHT = 4'd5;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] image_cols;
        logic [CFG_DIM_W-1:0] image_rows;
        logic [CFG_BOX_W-1:0] box_width;
        logic [CFG_BOX_W-1:0] box_height;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* rtl/weighted_centroid_peak_refine.sv */
// Top level: pixel counting, box test, moment sums on a shared multiplier, sequencer.
// Depends on wcp_pkg, wcp_apb_regs and wcp_div.
//
//  Channel  Dir  Handshake          Payload
//  s_       in   tvalid/tready      tdata: peak_x, peak_y, pixel_value; tuser: opcode; tlast
//  m_       out  tvalid/tready      tdata: centroid_x, centroid_y, total_weight;
//                                   tuser: zero_weight, saturated
//  apb      in   psel/penable       four 32-bit registers at byte addresses 0, 4, 8, 12
//
// A start word is taken without leaving ST_IDLE. A pixel word is accepted, then makes three passes
// through the single multiplier and the moment adders (x product, x add with y product,
// y add). The last pixel adds two divider runs, one per axis, unless the weight is zero,
// and then a load of the output register.
// Reset is synchronous, active low, and clears the counters, peak, sums and valid flag.
// A waiting result holds only the final load; new words are taken meanwhile.
module weighted_centroid_peak_refine #(
    parameter int MAX_DIM = wcp_pkg::DEF_MAX_DIM,
    parameter int MAX_BOX = wcp_pkg::DEF_MAX_BOX
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wcp_pkg::S_TDATA_W-1:0]   s_tdata,   // [9:0] peak_x, [19:10] peak_y,
                                                       // [35:20] pixel_value, [39:36] zero
    input  logic                            s_tuser,   // [0] opcode
    input  logic                            s_tlast,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wcp_pkg::M_TDATA_W-1:0]   m_tdata,   // [18:0] centroid_x, [37:19] centroid_y,
                                                       // [61:38] total_weight, [63:62] zero
    output logic [wcp_pkg::M_TUSER_W-1:0]   m_tuser,   // [0] zero_weight, [1] saturated
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wcp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wcp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wcp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int COORD_W  = $clog2(MAX_DIM);
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int XW       = COORD_W + 1;
    localparam int PW       = ((COORD_W > wcp_pkg::PEAK_W) ? COORD_W : wcp_pkg::PEAK_W) + 2;
    localparam int BOX_CAP  = (1 << wcp_pkg::CFG_BOX_W) - 1;
    localparam int BOX_LIM  = (MAX_BOX < BOX_CAP) ? MAX_BOX : BOX_CAP;
    localparam int BOX_SIDE = (BOX_LIM / 2) * 2 + 1;
    localparam int AREA_W   = $clog2(BOX_SIDE * BOX_SIDE);
    localparam int WW       = wcp_pkg::PIX_W + AREA_W;
    localparam int PROD_W   = COORD_W + wcp_pkg::PIX_W + 1;
    localparam int MW       = PROD_W + AREA_W;
    localparam int NUM_W    = MW + wcp_pkg::FRAC_W + 2;
    localparam int DEN_W    = WW + 1;
    localparam int HALF_W   = wcp_pkg::CFG_BOX_W - 1;
    localparam int CW       = wcp_pkg::CENT_W;
    localparam int QW       = wcp_pkg::QUO_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_ACC_X,
        ST_ACC_Y,
        ST_DIV_X,
        ST_DIV_Y,
        ST_FIN
    } state_t;

    state_t                         state_reg;

    wcp_pkg::cfg_t                  cfg;
    wcp_pkg::div_status_t           div_status;
    logic [QW-1:0]                  div_quo;
    logic                           div_start;
    logic [NUM_W-1:0]               div_num;
    logic [DEN_W-1:0]               div_den;

    // Frame state
    logic [COORD_W-1:0]             col_cnt_reg;
    logic [COORD_W-1:0]             row_cnt_reg;
    logic [wcp_pkg::PEAK_W-1:0]     peak_col_reg;
    logic [wcp_pkg::PEAK_W-1:0]     peak_row_reg;
    logic signed [WW-1:0]           weight_reg;
    logic signed [MW-1:0]           x_mom_reg;
    logic signed [MW-1:0]           y_mom_reg;

    // Captured pixel
    logic signed [wcp_pkg::PIX_W-1:0] pix_val_reg;
    logic [COORD_W-1:0]             pix_col_reg;
    logic [COORD_W-1:0]             pix_row_reg;
    logic                           pix_in_reg;
    logic                           pix_last_reg;
    logic signed [PROD_W-1:0]       prod_reg;

    // Result staging and output
    logic [CW-1:0]                  cent_x_reg;
    logic [CW-1:0]                  cent_y_reg;
    logic                           sat_reg;
    logic                           zero_reg;
    logic                           m_tvalid_reg;
    logic [wcp_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic [wcp_pkg::M_TUSER_W-1:0]  m_tuser_reg;

    // Input word fields
    logic [wcp_pkg::PEAK_W-1:0]     in_peak_x;
    logic [wcp_pkg::PEAK_W-1:0]     in_peak_y;
    logic signed [wcp_pkg::PIX_W-1:0] in_pixel;
    logic                           in_accept;

    // Combinational helpers
    logic [DIM_W-1:0]               eff_cols;
    logic [DIM_W-1:0]               eff_rows;
    logic [wcp_pkg::CFG_BOX_W-1:0]  bw_lim;
    logic [wcp_pkg::CFG_BOX_W-1:0]  bh_lim;
    logic [HALF_W-1:0]              half_x;
    logic [HALF_W-1:0]              half_y;
    logic                           in_box;
    logic [XW-1:0]                  col_inc;
    logic [XW-1:0]                  row_inc;
    logic [COORD_W-1:0]             mul_coord;
    logic signed [PROD_W-1:0]       mul_out;
    logic signed [MW-1:0]           mom_sel;
    logic [MW-1:0]                  mom_mag;
    logic [WW-1:0]                  w_mag;
    logic                           res_neg;
    logic                           res_sat;
    logic [CW-1:0]                  res_cent;
    logic                           out_free;

    wcp_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wcp_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (QW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .status  (div_status),
        .quo     (div_quo)
    );

    assign in_peak_x = s_tdata[wcp_pkg::PEAK_W-1:0];
    assign in_peak_y = s_tdata[2*wcp_pkg::PEAK_W-1:wcp_pkg::PEAK_W];
    assign in_pixel  = s_tdata[2*wcp_pkg::PEAK_W+wcp_pkg::PIX_W-1:2*wcp_pkg::PEAK_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid & s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Effective frame size: zero counts as one, clipped at MAX_DIM
    always_comb begin
        if (cfg.image_cols == '0) begin
            eff_cols = DIM_W'(1);
        end else if (32'(cfg.image_cols) > MAX_DIM) begin
            eff_cols = DIM_W'(MAX_DIM);
        end else begin
            eff_cols = DIM_W'(cfg.image_cols);
        end
        if (cfg.image_rows == '0) begin
            eff_rows = DIM_W'(1);
        end else if (32'(cfg.image_rows) > MAX_DIM) begin
            eff_rows = DIM_W'(MAX_DIM);
        end else begin
            eff_rows = DIM_W'(cfg.image_rows);
        end
    end

    // Box half sizes, box size clipped at MAX_BOX
    assign bw_lim = (32'(cfg.box_width) > MAX_BOX)  ? wcp_pkg::CFG_BOX_W'(MAX_BOX) : cfg.box_width;
    assign bh_lim = (32'(cfg.box_height) > MAX_BOX) ? wcp_pkg::CFG_BOX_W'(MAX_BOX) : cfg.box_height;
    assign half_x = bw_lim[wcp_pkg::CFG_BOX_W-1:1];
    assign half_y = bh_lim[wcp_pkg::CFG_BOX_W-1:1];

    // Clamped box test on the current counters
    assign in_box =
        (PW'(col_cnt_reg) + PW'(half_x) >= PW'(peak_col_reg)) &&
        (PW'(col_cnt_reg) <= PW'(peak_col_reg) + PW'(half_x)) &&
        (XW'(col_cnt_reg) < XW'(eff_cols)) &&
        (PW'(row_cnt_reg) + PW'(half_y) >= PW'(peak_row_reg)) &&
        (PW'(row_cnt_reg) <= PW'(peak_row_reg) + PW'(half_y)) &&
        (XW'(row_cnt_reg) < XW'(eff_rows));

    assign col_inc = XW'(col_cnt_reg) + XW'(1);
    assign row_inc = XW'(row_cnt_reg) + XW'(1);

    // Shared multiplier: column product first, then row product
    assign mul_coord = (state_reg == ST_MUL_X) ? pix_col_reg : pix_row_reg;
    assign mul_out   = PROD_W'($signed({1'b0, mul_coord})) * PROD_W'(pix_val_reg);

    // Divider operands: rounded Q.8 quotient (2*|m|*256 + |w|) / (2*|w|)
    assign mom_sel = (state_reg == ST_ACC_Y) ? x_mom_reg : y_mom_reg;
    assign mom_mag = mom_sel[MW-1] ? MW'(-mom_sel) : MW'(mom_sel);
    assign w_mag   = weight_reg[WW-1] ? WW'(-weight_reg) : WW'(weight_reg);
    assign div_num = (NUM_W'(mom_mag) << (wcp_pkg::FRAC_W + 1)) + NUM_W'(w_mag);
    assign div_den = DEN_W'(w_mag) << 1;
    assign div_start = ((state_reg == ST_ACC_Y) && pix_last_reg && (weight_reg != '0)) ||
                       ((state_reg == ST_DIV_X) && div_status.done);

    // Sign and saturation of the finished quotient
    always_comb begin
        res_neg = ((state_reg == ST_DIV_X) ? x_mom_reg[MW-1] : y_mom_reg[MW-1]) ^
                  weight_reg[WW-1];
        if (!res_neg) begin
            res_sat  = (div_quo > QW'(wcp_pkg::CENT_POS_MAX));
            res_cent = res_sat ? CW'(wcp_pkg::CENT_POS_MAX) : div_quo[CW-1:0];
        end else begin
            res_sat  = (div_quo > QW'(wcp_pkg::CENT_NEG_MAG));
            res_cent = res_sat ? CW'(wcp_pkg::CENT_NEG_MAG)
                               : CW'(-$signed({1'b0, div_quo}));
        end
    end

    // Sequencer, frame state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            peak_col_reg <= '0;
            peak_row_reg <= '0;
            weight_reg   <= '0;
            x_mom_reg    <= '0;
            y_mom_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // a new result load in ST_FIN takes the place of the clear
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (s_tuser == wcp_pkg::OP_START) begin
                            peak_col_reg <= in_peak_x;
                            peak_row_reg <= in_peak_y;
                            col_cnt_reg  <= '0;
                            row_cnt_reg  <= '0;
                            weight_reg   <= '0;
                            x_mom_reg    <= '0;
                            y_mom_reg    <= '0;
                        end else begin
                            pix_val_reg  <= in_pixel;
                            pix_col_reg  <= col_cnt_reg;
                            pix_row_reg  <= row_cnt_reg;
                            pix_in_reg   <= in_box;
                            pix_last_reg <= s_tlast;
                            // raster counters
                            if (col_inc >= XW'(eff_cols)) begin
                                col_cnt_reg <= '0;
                                if (row_inc >= XW'(eff_rows)) begin
                                    row_cnt_reg <= '0;
                                end else begin
                                    row_cnt_reg <= row_inc[COORD_W-1:0];
                                end
                            end else begin
                                col_cnt_reg <= col_inc[COORD_W-1:0];
                            end
                            state_reg <= ST_MUL_X;
                        end
                    end
                end
                ST_MUL_X: begin
                    prod_reg <= mul_out;
                    if (pix_in_reg) begin
                        weight_reg <= weight_reg + WW'(pix_val_reg);
                    end
                    state_reg <= ST_ACC_X;
                end
                ST_ACC_X: begin
                    if (pix_in_reg) begin
                        x_mom_reg <= x_mom_reg + MW'(prod_reg);
                    end
                    prod_reg  <= mul_out;
                    state_reg <= ST_ACC_Y;
                end
                ST_ACC_Y: begin
                    if (pix_in_reg) begin
                        y_mom_reg <= y_mom_reg + MW'(prod_reg);
                    end
                    if (!pix_last_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (weight_reg == '0) begin
                        // zero weight: centroids forced to zero
                        zero_reg   <= 1'b1;
                        sat_reg    <= 1'b0;
                        cent_x_reg <= '0;
                        cent_y_reg <= '0;
                        state_reg  <= ST_FIN;
                    end else begin
                        zero_reg  <= 1'b0;
                        state_reg <= ST_DIV_X;
                    end
                end
                ST_DIV_X: begin
                    if (div_status.done) begin
                        cent_x_reg <= res_cent;
                        sat_reg    <= res_sat;
                        state_reg  <= ST_DIV_Y;
                    end
                end
                ST_DIV_Y: begin
                    if (div_status.done) begin
                        cent_y_reg <= res_cent;
                        sat_reg    <= sat_reg | res_sat;
                        state_reg  <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        // weight sum goes out as a 24-bit two's complement field
                        m_tdata_reg  <= wcp_pkg::M_TDATA_W'({wcp_pkg::TW_W'(weight_reg),
                                                             cent_y_reg, cent_x_reg});
                        m_tuser_reg  <= {sat_reg, zero_reg};
                        m_tvalid_reg <= 1'b1;
                        col_cnt_reg  <= '0;
                        row_cnt_reg  <= '0;
                        weight_reg   <= '0;
                        x_mom_reg    <= '0;
                        y_mom_reg    <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_div_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> !s_tready)
        else $error("input taken while the divider is running");

    a_zero_weight_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (!m_tuser[1] && (m_tdata[2*CW-1:0] == '0)))
        else $error("zero weight result with nonzero centroid or saturation");

    a_pixel_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == wcp_pkg::OP_PIXEL)) |=> !s_tready)
        else $error("ready did not drop after a pixel word");

    a_start_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == wcp_pkg::OP_START)) |=> s_tready)
        else $error("start word did not complete in one cycle");

endmodule

/* rtl/wcp_apb_regs.sv */
// APB configuration registers: frame size and weighting box size.
// Depends on wcp_pkg for the register map, widths and reset values.
module wcp_apb_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wcp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wcp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wcp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output wcp_pkg::cfg_t                   cfg
);

    wcp_pkg::cfg_t                    cfg_reg;
    logic [wcp_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                             wr_en;

    assign reg_idx = paddr[wcp_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Register writes on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_cols <= wcp_pkg::RST_IMAGE_COLS;
            cfg_reg.image_rows <= wcp_pkg::RST_IMAGE_ROWS;
            cfg_reg.box_width  <= wcp_pkg::RST_BOX_WIDTH;
            cfg_reg.box_height <= wcp_pkg::RST_BOX_HEIGHT;
        end else if (wr_en) begin
            unique case (reg_idx)
                wcp_pkg::REG_IMAGE_COLS: begin
                    cfg_reg.image_cols <= pwdata[wcp_pkg::CFG_DIM_W-1:0];
                end
                wcp_pkg::REG_IMAGE_ROWS: begin
                    cfg_reg.image_rows <= pwdata[wcp_pkg::CFG_DIM_W-1:0];
                end
                wcp_pkg::REG_BOX_WIDTH: begin
                    cfg_reg.box_width <= pwdata[wcp_pkg::CFG_BOX_W-1:0];
                end
                wcp_pkg::REG_BOX_HEIGHT: begin
                    cfg_reg.box_height <= pwdata[wcp_pkg::CFG_BOX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            wcp_pkg::REG_IMAGE_COLS: prdata = wcp_pkg::APB_DATA_W'(cfg_reg.image_cols);
            wcp_pkg::REG_IMAGE_ROWS: prdata = wcp_pkg::APB_DATA_W'(cfg_reg.image_rows);
            wcp_pkg::REG_BOX_WIDTH:  prdata = wcp_pkg::APB_DATA_W'(cfg_reg.box_width);
            wcp_pkg::REG_BOX_HEIGHT: prdata = wcp_pkg::APB_DATA_W'(cfg_reg.box_height);
            default:                 prdata = '0;
        endcase
    end

endmodule

/* rtl/wcp_div.sv */
// Restoring divider, one quotient bit per cycle, shared by both centroid axes.
// Depends on wcp_pkg for the status struct; widths come from the top level.
module wcp_div #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 25,
    parameter int QUO_W = wcp_pkg::QUO_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output wcp_pkg::div_status_t  status,
    output logic [QUO_W-1:0]      quo
);

    localparam int SHD_W = DEN_W + QUO_W - 1;
    localparam int DV_W  = (NUM_W > SHD_W) ? NUM_W : SHD_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DV_W-1:0]   rem_reg,  rem_next;
    logic [DV_W-1:0]   dsh_reg,  dsh_next;
    logic [QUO_W-1:0]  quo_reg,  quo_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fits;

    // One trial subtract of the shifted divisor
    assign fits     = (rem_reg >= dsh_reg);
    assign rem_next = fits ? (rem_reg - dsh_reg) : rem_reg;
    assign dsh_next = dsh_reg >> 1;
    assign quo_next = {quo_reg[QUO_W-2:0], fits};

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quo         = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
                rem_reg  <= DV_W'(num);
                dsh_reg  <= DV_W'(den) << (QUO_W - 1);
                quo_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dsh_reg <= dsh_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
